/* hw/rtl/pps_pkg.sv */
// Package with types and constants shared by the poll scheduler files.
package pps_pkg;

  localparam int unsigned NUM_GROUPS  = 5;
  localparam int unsigned BLOCK_COUNT = 14;
  localparam int unsigned CFG_AW      = 5;

  typedef enum logic [1:0] {
    FUNC_POLL = 2'd0,
    FUNC_RESP = 2'd1,
    FUNC_SYNC = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    REG_LIVE     = 3'd0,
    REG_STATS    = 3'd1,
    REG_SETTINGS = 3'd2,
    REG_BATTERY  = 3'd3,
    REG_INFO     = 3'd4,
    REG_TIMEOUT  = 3'd5
  } reg_idx_e;

  // Group order: device info, live, stats, settings, battery.
  localparam int unsigned GRP_INFO     = 0;
  localparam int unsigned GRP_LIVE     = 1;
  localparam int unsigned GRP_STATS    = 2;
  localparam int unsigned GRP_SETTINGS = 3;
  localparam int unsigned GRP_BATTERY  = 4;

  localparam logic [BLOCK_COUNT-1:0] GROUP_MASK [NUM_GROUPS] = '{
    14'h0001, 14'h000C, 14'h00F0, 14'h0700, 14'h3800
  };
  localparam logic [BLOCK_COUNT-1:0] TIME_BLOCK_MASK = 14'h0002;

  localparam logic [31:0] RST_LIVE     = 32'd10000;
  localparam logic [31:0] RST_STATS    = 32'd60000;
  localparam logic [31:0] RST_SETTINGS = 32'd300000;
  localparam logic [31:0] RST_BATTERY  = 32'd60000;
  localparam logic [31:0] RST_INFO     = 32'd3600000;
  localparam logic [31:0] RST_TIMEOUT  = 32'd5000;

  typedef struct packed {
    logic [NUM_GROUPS-1:0][31:0] interval;
    logic [31:0]                 timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                   issued;
    logic [3:0]             issued_blk;
    logic                   busy_res;
    logic [BLOCK_COUNT-1:0] pending_mask;
  } out_item_t;

endpackage

/* hw/rtl/pps_in_if.sv */
// Input item channel of the poll scheduler.
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;

  modport source (output valid, output func, output now_ms, input ready);
  modport sink (input valid, input func, input now_ms, output ready);
endinterface

/* hw/rtl/pps_out_if.sv */
// Result item channel of the poll scheduler.
interface pps_out_if;
  logic        valid;
  logic        ready;
  logic        issued;
  logic [3:0]  issued_blk;
  logic        busy_res;
  logic [13:0] pending_mask;

  modport source (output valid, output issued, output issued_blk, output busy_res,
                  output pending_mask, input ready);
  modport sink (input valid, input issued, input issued_blk, input busy_res,
                input pending_mask, output ready);
endinterface

/* hw/rtl/pps_sched_core.sv */
// Scheduler state and the single-pass due check, timeout check and priority issue.
module pps_sched_core import pps_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic [NUM_GROUPS-1:0][TIME_WIDTH-1:0] due_q, due_d;
  logic [BLOCK_COUNT-1:0]                pend_q, pend_d;
  logic                                  busy_q, busy_d;
  logic [TIME_WIDTH-1:0]                 start_q, start_d;

  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] age;
  logic                  blocked;
  logic [3:0]            first_idx;

  function automatic logic [3:0] first_set(input logic [BLOCK_COUNT-1:0] mask);
    logic [3:0] idx;
    idx = '0;
    for (int i = BLOCK_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  assign now_ext = {32'b0, item_i.now_ms};
  assign now_t   = now_ext[TIME_WIDTH-1:0];
  assign age     = now_t - start_q;
  assign blocked = busy_q && (64'(age) < {32'b0, cfg_i.timeout});

  always_comb begin
    logic [63:0] ival_ext;
    ival_ext  = '0;
    due_d     = due_q;
    pend_d    = pend_q;
    busy_d    = busy_q;
    start_d   = start_q;
    first_idx = '0;
    result_o  = '0;
    case (item_i.func)
      FUNC_POLL: begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          ival_ext = {32'b0, cfg_i.interval[g]};
          if (now_t >= due_q[g]) begin
            pend_d   = pend_d | GROUP_MASK[g];
            due_d[g] = now_t + ival_ext[TIME_WIDTH-1:0];
          end
        end
        first_idx = first_set(pend_d);
        if ((pend_d != '0) && !blocked) begin
          pend_d[first_idx]   = 1'b0;
          busy_d              = 1'b1;
          start_d             = now_t;
          result_o.issued     = 1'b1;
          result_o.issued_blk = first_idx;
        end
      end
      FUNC_RESP: begin
        busy_d = 1'b0;
      end
      FUNC_SYNC: begin
        pend_d = pend_d | TIME_BLOCK_MASK;
      end
      default: begin
      end
    endcase
    result_o.busy_res     = busy_d;
    result_o.pending_mask = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q   <= '0;
      pend_q  <= '0;
      busy_q  <= 1'b0;
      start_q <= '0;
    end else if (step_i) begin
      due_q   <= due_d;
      pend_q  <= pend_d;
      busy_q  <= busy_d;
      start_q <= start_d;
    end
  end

endmodule

/* hw/rtl/periodic_poll_priority_scheduler_unit.sv */
// Top level of the periodic poll scheduler: register port, item registers and result register.
// An accepted item is held in the item register and its result is loaded into the result register,
// which waits until the output has taken the previous result. Throughput: one item per cycle
// while the output takes results; the due compares, the timeout compare and the priority
// encoder sit in one combinational pass between the input and result registers.
// Reset clears all due times, pending bits, the busy flag and both item stages,
// and loads the interval and timeout registers with their default values.
module periodic_poll_priority_scheduler_unit import pps_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  pps_in_if.sink            in_i,
  pps_out_if.source         out_o
);

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      step;
  logic      cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval[GRP_INFO]     <= RST_INFO;
      cfg_q.interval[GRP_LIVE]     <= RST_LIVE;
      cfg_q.interval[GRP_STATS]    <= RST_STATS;
      cfg_q.interval[GRP_SETTINGS] <= RST_SETTINGS;
      cfg_q.interval[GRP_BATTERY]  <= RST_BATTERY;
      cfg_q.timeout                <= RST_TIMEOUT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LIVE:     cfg_q.interval[GRP_LIVE]     <= pwdata;
        REG_STATS:    cfg_q.interval[GRP_STATS]    <= pwdata;
        REG_SETTINGS: cfg_q.interval[GRP_SETTINGS] <= pwdata;
        REG_BATTERY:  cfg_q.interval[GRP_BATTERY]  <= pwdata;
        REG_INFO:     cfg_q.interval[GRP_INFO]     <= pwdata;
        REG_TIMEOUT:  cfg_q.timeout                <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LIVE:     prdata = cfg_q.interval[GRP_LIVE];
      REG_STATS:    prdata = cfg_q.interval[GRP_STATS];
      REG_SETTINGS: prdata = cfg_q.interval[GRP_SETTINGS];
      REG_BATTERY:  prdata = cfg_q.interval[GRP_BATTERY];
      REG_INFO:     prdata = cfg_q.interval[GRP_INFO];
      REG_TIMEOUT:  prdata = cfg_q.timeout;
      default:      prdata = '0;
    endcase
  end

  // The registered item moves into the result register when it is free or its result is taken.
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.func   <= in_i.func;
      in_q.now_ms <= in_i.now_ms;
    end
  end

  pps_sched_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.issued       = out_q.issued;
  assign out_o.issued_blk   = out_q.issued_blk;
  assign out_o.busy_res     = out_q.busy_res;
  assign out_o.pending_mask = out_q.pending_mask;

  a_issue_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.issued |-> out_q.busy_res)
    else $error("issued result without busy flag");

  a_issue_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.issued |->
      (out_q.issued_blk < 4'(BLOCK_COUNT)) && !out_q.pending_mask[out_q.issued_blk])
    else $error("issued block still pending or out of range");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_q))
    else $error("input stage lost an item");

endmodule
